[design/tpmv_pkg.sv]
// Shared types, constants and weight decode functions for the ternary matrix-vector unit.
`timescale 1ns / 1ps

package tpmv_pkg;

  // Field and register widths.
  localparam int unsigned LEN_W      = 13;
  localparam int unsigned ROWCNT_W   = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned ACT_W      = 16;
  localparam int unsigned ACT_IDX_W  = 12;
  localparam int unsigned NIB_W      = 4;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned ROW_IDX_W  = 8;
  localparam int unsigned CONTRIB_W  = 18;
  localparam int unsigned LANES      = 3;

  // Default sizes of the activation store and the row counter.
  localparam int unsigned DEF_MAX_ACTIVATIONS = 4096;
  localparam int unsigned DEF_MAX_ROWS        = 256;

  // Register values after reset.
  localparam int unsigned THREE_LEN_RST = 0;
  localparam int unsigned TWO_LEN_RST   = 32;
  localparam int unsigned ROW_COUNT_RST = 32;

  // Division by three of a LEN_W-bit value: multiply by this and drop DIV3_SHIFT bits.
  localparam int unsigned DIV3_MUL   = 2731;
  localparam int unsigned DIV3_SHIFT = 13;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THREE_LEN = 2'd0,
    CFG_TWO_LEN   = 2'd1,
    CFG_ROW_COUNT = 2'd2
  } cfg_reg_e;

  // A ternary weight in two's complement.
  typedef logic [1:0] wgt_t;
  localparam wgt_t W_ZERO = 2'b00;
  localparam wgt_t W_POS  = 2'b01;
  localparam wgt_t W_NEG  = 2'b11;

  // Row geometry as seen by the sequencer.
  typedef struct packed {
    logic [LEN_W-1:0]    three_len;
    logic [LEN_W-1:0]    g3;
    logic [LEN_W-1:0]    total;
    logic [ROWCNT_W-1:0] rows;
  } tpmv_cfg_t;

  // One weight group on its way to the accumulator, aligned with the store read data.
  typedef struct packed {
    logic                 valid;
    logic                 last;
    wgt_t [LANES-1:0]     wgt;
    logic [ROW_IDX_W-1:0] row_index;
    logic [SUM_W-1:0]     prior;
  } tpmv_issue_t;

  // Three-weight code table; element 0 is the weight of the first activation.
  function automatic wgt_t [2:0] dec3(input logic [NIB_W-1:0] code);
    wgt_t [2:0] r;
    unique case (code)
      4'd0:  r = {W_ZERO, W_ZERO, W_ZERO};
      4'd1:  r = {W_POS,  W_ZERO, W_ZERO};
      4'd2:  r = {W_NEG,  W_ZERO, W_ZERO};
      4'd3:  r = {W_ZERO, W_POS,  W_ZERO};
      4'd4:  r = {W_POS,  W_POS,  W_ZERO};
      4'd5:  r = {W_NEG,  W_POS,  W_ZERO};
      4'd6:  r = {W_ZERO, W_NEG,  W_ZERO};
      4'd7:  r = {W_POS,  W_NEG,  W_ZERO};
      4'd8:  r = {W_NEG,  W_NEG,  W_ZERO};
      4'd9:  r = {W_ZERO, W_ZERO, W_POS};
      4'd10: r = {W_POS,  W_ZERO, W_POS};
      4'd11: r = {W_NEG,  W_ZERO, W_POS};
      4'd12: r = {W_ZERO, W_POS,  W_POS};
      4'd13: r = {W_POS,  W_POS,  W_POS};
      4'd14: r = {W_NEG,  W_POS,  W_POS};
      4'd15: r = {W_ZERO, W_ZERO, W_NEG};
    endcase
    return r;
  endfunction

  // Two-weight code table; codes from nine up decode to zero weights.
  function automatic wgt_t [1:0] dec2(input logic [NIB_W-1:0] code);
    wgt_t [1:0] r;
    unique case (code)
      4'd0:    r = {W_NEG,  W_NEG};
      4'd1:    r = {W_ZERO, W_NEG};
      4'd2:    r = {W_POS,  W_NEG};
      4'd3:    r = {W_NEG,  W_ZERO};
      4'd4:    r = {W_ZERO, W_ZERO};
      4'd5:    r = {W_POS,  W_ZERO};
      4'd6:    r = {W_NEG,  W_POS};
      4'd7:    r = {W_ZERO, W_POS};
      4'd8:    r = {W_POS,  W_POS};
      default: r = {W_ZERO, W_ZERO};
    endcase
    return r;
  endfunction

  // Negation of one weight.
  function automatic wgt_t wneg(input wgt_t w);
    wgt_t r;
    unique case (w)
      W_POS:   r = W_NEG;
      W_NEG:   r = W_POS;
      default: r = W_ZERO;
    endcase
    return r;
  endfunction

endpackage

[design/tpmv_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module tpmv_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/tpmv_cfg.sv]
// Configuration registers and the row geometry derived from them.
`timescale 1ns / 1ps

module tpmv_cfg #(
  parameter int unsigned MAX_ROWS = tpmv_pkg::DEF_MAX_ROWS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tpmv_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tpmv_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output tpmv_pkg::tpmv_cfg_t              cfg_o
);

  import tpmv_pkg::*;

  localparam int unsigned ROWS_RST = (ROW_COUNT_RST > MAX_ROWS) ? MAX_ROWS : ROW_COUNT_RST;
  localparam int unsigned PROD_W   = LEN_W + DIV3_SHIFT;

  logic [LEN_W-1:0]    three_len_q, three_len_d;
  logic [LEN_W-1:0]    g3_q, g3_d;
  logic [LEN_W-1:0]    g2_q, g2_d;
  logic [ROWCNT_W-1:0] rows_q, rows_d;
  logic [PROD_W-1:0]   div3_prod;
  logic [ROWCNT_W-1:0] rows_wr;
  logic [ROWCNT_W-1:0] rows_clamped;
  cfg_reg_e            reg_sel;

  // Group count of the three-weight part: divide by three through a reciprocal multiply.
  assign div3_prod = PROD_W'(cfg_data_i[LEN_W-1:0]) * PROD_W'(DIV3_MUL);

  // A row count of zero means one row; counts past the row capacity saturate.
  assign rows_wr = cfg_data_i[ROWCNT_W-1:0];
  always_comb begin
    if (rows_wr == '0) begin
      rows_clamped = ROWCNT_W'(1);
    end else if (32'(rows_wr) > MAX_ROWS) begin
      rows_clamped = ROWCNT_W'(MAX_ROWS);
    end else begin
      rows_clamped = rows_wr;
    end
  end

  assign reg_sel = cfg_reg_e'(cfg_index_i);

  // Register write decode; indexes past the list are dropped.
  always_comb begin
    three_len_d = three_len_q;
    g3_d        = g3_q;
    g2_d        = g2_q;
    rows_d      = rows_q;
    if (cfg_we_i) begin
      unique case (reg_sel)
        CFG_THREE_LEN: begin
          three_len_d = cfg_data_i[LEN_W-1:0];
          g3_d        = div3_prod[PROD_W-1:DIV3_SHIFT];
        end
        CFG_TWO_LEN: begin
          g2_d = {1'b0, cfg_data_i[LEN_W-1:1]};
        end
        CFG_ROW_COUNT: begin
          rows_d = rows_clamped;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      three_len_q <= LEN_W'(THREE_LEN_RST);
      g3_q        <= LEN_W'(THREE_LEN_RST / 3);
      g2_q        <= LEN_W'(TWO_LEN_RST / 2);
      rows_q      <= ROWCNT_W'(ROWS_RST);
    end else begin
      three_len_q <= three_len_d;
      g3_q        <= g3_d;
      g2_q        <= g2_d;
      rows_q      <= rows_d;
    end
  end

  // Groups per row never exceed 2730 + 4095, so the sum fits the length width.
  assign cfg_o.three_len = three_len_q;
  assign cfg_o.g3        = g3_q;
  assign cfg_o.total     = g3_q + g2_q;
  assign cfg_o.rows      = rows_q;

endmodule

[design/tpmv_seq.sv]
// Input sequencer: row and group position, store addressing and weight decode.
`timescale 1ns / 1ps

module tpmv_seq #(
  parameter int unsigned MAX_ACTIVATIONS = tpmv_pkg::DEF_MAX_ACTIVATIONS,
  parameter int unsigned MAX_ROWS        = tpmv_pkg::DEF_MAX_ROWS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tpmv_pkg::tpmv_cfg_t                 cfg_i,
  input  logic                                hold_i,
  input  logic                                in_valid_i,
  input  logic                                kind_i,
  input  logic [tpmv_pkg::ACT_IDX_W-1:0]      act_index_i,
  input  logic signed [tpmv_pkg::ACT_W-1:0]   act_value_i,
  input  logic [tpmv_pkg::NIB_W-1:0]          nibble_i,
  input  logic                                negate_i,
  input  logic signed [tpmv_pkg::SUM_W-1:0]   prior_value_i,
  output logic                                ram_we_o,
  output logic [$clog2(MAX_ACTIVATIONS)-1:0]  ram_waddr_o,
  output logic [tpmv_pkg::ACT_W-1:0]          ram_wdata_o,
  output logic [$clog2(MAX_ACTIVATIONS)-1:0]  ram_raddr_o [tpmv_pkg::LANES],
  output tpmv_pkg::tpmv_issue_t               issue_o
);

  import tpmv_pkg::*;

  localparam int unsigned AW       = $clog2(MAX_ACTIVATIONS);
  localparam int unsigned BASE_W   = LEN_W + 2;
  localparam int unsigned ROWS_CAP = (MAX_ROWS > ((1 << ROWCNT_W) - 1)) ?
                                     ((1 << ROWCNT_W) - 1) : MAX_ROWS;
  localparam int unsigned RP_W     = (ROWS_CAP > 1) ? $clog2(ROWS_CAP) : 1;
  localparam int unsigned CW       = ((RP_W > ROWCNT_W) ? RP_W : ROWCNT_W) + 1;

  logic [LEN_W-1:0]           gp_q, gp_d;
  logic [RP_W-1:0]            rowp_q, rowp_d;
  logic                       accept;
  logic                       wgt_item;
  logic                       in_three;
  logic                       in_row;
  logic                       last;
  logic [LEN_W-1:0]           gp_rel;
  logic [BASE_W-1:0]          base3;
  logic [BASE_W-1:0]          base2;
  logic [BASE_W-1:0]          base;
  logic [AW+ACT_IDX_W-1:0]    widx_pad;
  logic [CW-1:0]              rowp_inc;
  logic [RP_W+ROW_IDX_W-1:0]  rowp_pad;
  wgt_t [LANES-1:0]           wgt;
  wgt_t [2:0]                 w3;
  wgt_t [1:0]                 w2;
  logic                       valid_q;
  logic                       last_q;
  wgt_t [LANES-1:0]           wgt_q;
  logic [ROW_IDX_W-1:0]       row_index_q;
  logic [SUM_W-1:0]           prior_q;

  assign accept   = in_valid_i && !hold_i;
  assign wgt_item = accept && kind_i && (cfg_i.total != '0);
  assign in_three = gp_q < cfg_i.g3;
  assign in_row   = gp_q < cfg_i.total;
  assign last     = ({1'b0, gp_q} + 1'b1) >= {1'b0, cfg_i.total};

  // Activation load: the same value goes to every bank, address taken modulo the depth.
  assign widx_pad    = {AW'(0), act_index_i};
  assign ram_we_o    = accept && !kind_i;
  assign ram_waddr_o = widx_pad[AW-1:0];
  assign ram_wdata_o = act_value_i;

  // First activation of the group: three per group, or after the three-weight part two each.
  assign gp_rel = gp_q - cfg_i.g3;
  assign base3  = {1'b0, gp_q, 1'b0} + {2'b00, gp_q};
  assign base2  = {2'b00, cfg_i.three_len} + {1'b0, gp_rel, 1'b0};
  assign base   = in_three ? base3 : base2;

  for (genvar i = 0; i < LANES; i++) begin : g_addr
    logic [BASE_W-1:0]    lane_addr;
    logic [AW+BASE_W-1:0] lane_pad;
    assign lane_addr      = base + BASE_W'(i);
    assign lane_pad       = {AW'(0), lane_addr};
    assign ram_raddr_o[i] = lane_pad[AW-1:0];
  end

  // Weight decode for the part of the row the group falls in.
  assign w3 = dec3(nibble_i);
  assign w2 = dec2(nibble_i);
  always_comb begin
    wgt = {W_ZERO, W_ZERO, W_ZERO};
    if (in_three) begin
      for (int i = 0; i < LANES; i++) begin
        wgt[i] = negate_i ? wneg(w3[i]) : w3[i];
      end
    end else if (in_row) begin
      wgt[0] = w2[0];
      wgt[1] = w2[1];
    end
  end

  // The group position advances on every weight group of a non-empty row, the row position on its last.
  assign rowp_inc = CW'(rowp_q) + 1'b1;
  always_comb begin
    gp_d   = gp_q;
    rowp_d = rowp_q;
    if (wgt_item) begin
      if (last) begin
        gp_d = '0;
        if (rowp_inc >= CW'(cfg_i.rows)) begin
          rowp_d = '0;
        end else begin
          rowp_d = rowp_inc[RP_W-1:0];
        end
      end else begin
        gp_d = gp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gp_q    <= '0;
      rowp_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      gp_q   <= gp_d;
      rowp_q <= rowp_d;
      if (!hold_i) begin
        valid_q <= wgt_item;
      end
    end
  end

  // Group attributes are registered to meet the store read data.
  assign rowp_pad = {ROW_IDX_W'(0), rowp_q};
  always_ff @(posedge clk_i) begin
    if (!hold_i) begin
      last_q      <= last;
      wgt_q       <= wgt;
      row_index_q <= rowp_pad[ROW_IDX_W-1:0];
      prior_q     <= prior_value_i;
    end
  end

  assign issue_o.valid     = valid_q;
  assign issue_o.last      = last_q;
  assign issue_o.wgt       = wgt_q;
  assign issue_o.row_index = row_index_q;
  assign issue_o.prior     = prior_q;

endmodule

[design/tpmv_acc.sv]
// Weighted sum of the read activations, row accumulator and output register.
`timescale 1ns / 1ps

module tpmv_acc (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                hold_i,
  input  tpmv_pkg::tpmv_issue_t               issue_i,
  input  logic [tpmv_pkg::ACT_W-1:0]          act_i [tpmv_pkg::LANES],
  output logic                                out_valid_o,
  output logic [tpmv_pkg::ROW_IDX_W-1:0]      row_index_o,
  output logic signed [tpmv_pkg::SUM_W-1:0]   row_value_o
);

  import tpmv_pkg::*;

  // One weighted activation.
  function automatic logic signed [CONTRIB_W-1:0] term(input wgt_t w,
                                                       input logic [ACT_W-1:0] a);
    logic signed [CONTRIB_W-1:0] ax;
    logic signed [CONTRIB_W-1:0] r;
    ax = CONTRIB_W'($signed(a));
    unique case (w)
      W_POS:   r = ax;
      W_NEG:   r = -ax;
      default: r = '0;
    endcase
    return r;
  endfunction

  logic signed [CONTRIB_W-1:0] contrib;
  logic                        b_valid_q;
  logic                        b_last_q;
  logic [ROW_IDX_W-1:0]        b_row_q;
  logic [SUM_W-1:0]            b_prior_q;
  logic signed [CONTRIB_W-1:0] b_contrib_q;
  logic [SUM_W-1:0]            acc_q, acc_d;
  logic [SUM_W-1:0]            sum_all;
  logic                        out_valid_q, out_valid_d;
  logic [ROW_IDX_W-1:0]        out_row_q;
  logic [SUM_W-1:0]            out_value_q;

  // Contribution of one group: up to three signed activations.
  assign contrib = term(issue_i.wgt[0], act_i[0]) + term(issue_i.wgt[1], act_i[1]) +
                   term(issue_i.wgt[2], act_i[2]);

  // Row accumulation; the last group of a row folds in the prior value and clears the sum.
  assign sum_all = acc_q + SUM_W'(b_contrib_q);
  always_comb begin
    acc_d       = acc_q;
    out_valid_d = 1'b0;
    if (b_valid_q) begin
      if (b_last_q) begin
        acc_d       = '0;
        out_valid_d = 1'b1;
      end else begin
        acc_d = sum_all;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (!hold_i) begin
      b_valid_q   <= issue_i.valid;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload of the contribution stage and of the output register.
  always_ff @(posedge clk_i) begin
    if (!hold_i) begin
      b_last_q    <= issue_i.last;
      b_row_q     <= issue_i.row_index;
      b_prior_q   <= issue_i.prior;
      b_contrib_q <= contrib;
      out_row_q   <= b_row_q;
      out_value_q <= b_prior_q + sum_all;
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_index_o = out_row_q;
  assign row_value_o = out_value_q;

endmodule

[design/ternary_packed_matvec_unit.sv]
// Top level of the ternary-weight packed matrix-vector unit.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i / in_stall_o  kind, act_index, act_value, nibble, negate,
//                                                 prior_value
//   out       output     out_valid_o / out_stall_i row_index, row_value
//   cfg       input      cfg_we_i                cfg_index_i, cfg_data_i
//
// One input transaction per cycle while in_stall_o is low: a weight group reads its up to three
// activations from three copies of the activation store in the same cycle, one read port each.
// The edge that takes a row's last group registers the store read and the group attributes;
// the contribution stage and then the output register follow, and the latter raises out_valid_o.
// Reset clears positions, running sum and valid flags, resets the config; the store is not cleared.
// in_stall_o is high only while a result waits and out_stall_i is high; the whole pipe holds.
`timescale 1ns / 1ps

module ternary_packed_matvec_unit #(
  parameter int unsigned MAX_ACTIVATIONS = tpmv_pkg::DEF_MAX_ACTIVATIONS,
  parameter int unsigned MAX_ROWS        = tpmv_pkg::DEF_MAX_ROWS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               kind_i,
  input  logic [tpmv_pkg::ACT_IDX_W-1:0]     act_index_i,
  input  logic signed [tpmv_pkg::ACT_W-1:0]  act_value_i,
  input  logic [tpmv_pkg::NIB_W-1:0]         nibble_i,
  input  logic                               negate_i,
  input  logic signed [tpmv_pkg::SUM_W-1:0]  prior_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [tpmv_pkg::ROW_IDX_W-1:0]     row_index_o,
  output logic signed [tpmv_pkg::SUM_W-1:0]  row_value_o,
  input  logic                               cfg_we_i,
  input  logic [tpmv_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tpmv_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  import tpmv_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ACTIVATIONS);

  tpmv_cfg_t        cfg;
  tpmv_issue_t      issue;
  logic             hold;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [ACT_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr [LANES];
  logic [ACT_W-1:0] act_rd [LANES];

  // The pipe holds while a finished result is not taken.
  assign hold       = out_valid_o && out_stall_i;
  assign in_stall_o = hold;

  tpmv_cfg #(
    .MAX_ROWS (MAX_ROWS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tpmv_seq #(
    .MAX_ACTIVATIONS (MAX_ACTIVATIONS),
    .MAX_ROWS        (MAX_ROWS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .hold_i        (hold),
    .in_valid_i    (in_valid_i),
    .kind_i        (kind_i),
    .act_index_i   (act_index_i),
    .act_value_i   (act_value_i),
    .nibble_i      (nibble_i),
    .negate_i      (negate_i),
    .prior_value_i (prior_value_i),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_o   (ram_raddr),
    .issue_o       (issue)
  );

  // One store copy per activation of a group, all written together.
  for (genvar i = 0; i < LANES; i++) begin : g_bank
    tpmv_ram #(
      .WIDTH (ACT_W),
      .DEPTH (MAX_ACTIVATIONS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we),
      .waddr_i (ram_waddr),
      .wdata_i (ram_wdata),
      .re_i    (!hold),
      .raddr_i (ram_raddr[i]),
      .rdata_o (act_rd[i])
    );
  end

  tpmv_acc u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hold_i      (hold),
    .issue_i     (issue),
    .act_i       (act_rd),
    .out_valid_o (out_valid_o),
    .row_index_o (row_index_o),
    .row_value_o (row_value_o)
  );

endmodule

[test/ternary_packed_matvec_unit_tb.sv]
// Self-checking testbench for the ternary packed matrix-vector unit.
`timescale 1ns / 1ps

module ternary_packed_matvec_unit_tb;

  localparam int unsigned ACT_DEPTH     = tpmv_pkg::DEF_MAX_ACTIVATIONS;
  localparam int unsigned ROW_LIMIT     = tpmv_pkg::DEF_MAX_ROWS;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned ACT_WINDOW    = 256;
  localparam int unsigned GP_CAP        = 32;
  localparam logic        KIND_LOAD     = 1'b0;
  localparam logic        KIND_GROUP    = 1'b1;
  localparam logic [3:0]  TRIPLE_ALT    = 4'hF;
  localparam int unsigned PAIR_CODES    = 9;
  localparam logic [tpmv_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic               kind;
    logic [11:0]        act_index;
    logic signed [15:0] act_value;
    logic [3:0]         nibble;
    logic               negate;
    logic signed [31:0] prior_value;
  } matvec_item_t;

  typedef struct {
    logic [7:0]         row_index;
    logic signed [31:0] row_value;
  } row_result_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               kind = 1'b0;
  logic [11:0]        act_index = '0;
  logic signed [15:0] act_value = '0;
  logic [3:0]         nibble = '0;
  logic               negate = 1'b0;
  logic signed [31:0] prior_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         row_index;
  logic signed [31:0] row_value;
  logic               cfg_we = 1'b0;
  logic [tpmv_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tpmv_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Transactions waiting for the driver and row results waiting for the output.
  matvec_item_t pending[$];
  row_result_t  rows_due[$];

  // Predicted state of the unit.
  logic signed [15:0] act_mem [ACT_DEPTH];
  int unsigned        grp_pos = 0;
  int unsigned        row_pos = 0;
  logic [31:0]        run_sum = '0;
  logic [12:0]        reg_three_len = 13'(tpmv_pkg::THREE_LEN_RST);
  logic [12:0]        reg_two_len = 13'(tpmv_pkg::TWO_LEN_RST);
  logic [8:0]         reg_row_count = 9'(tpmv_pkg::ROW_COUNT_RST);

  // Bookkeeping shared between driver, monitor and the run plan.
  logic        item_taken = 1'b0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  int unsigned mismatch_count = 0;
  int unsigned items_taken = 0;
  int unsigned results_checked = 0;
  int unsigned settings_used = 0;

  ternary_packed_matvec_unit i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .kind_i       (kind),
    .act_index_i  (act_index),
    .act_value_i  (act_value),
    .nibble_i     (nibble),
    .negate_i     (negate),
    .prior_value_i(prior_value),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .row_index_o  (row_index),
    .row_value_o  (row_value),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Weight of one lane of a three-weight code; codes count up in base three.
  function automatic int triple_weight(input logic [3:0] code, input int lane);
    int digit;
    if (code == TRIPLE_ALT) return (lane == 0) ? -1 : 0;
    digit = (int'(code) / ((lane == 0) ? 9 : ((lane == 1) ? 3 : 1))) % 3;
    return (digit == 2) ? -1 : digit;
  endfunction

  // Weight of one lane of a two-weight code.
  function automatic int pair_weight(input logic [3:0] code, input int lane);
    if (int'(code) >= PAIR_CODES) return 0;
    return (lane == 0) ? (int'(code) / 3 - 1) : (int'(code) % 3 - 1);
  endfunction

  // Adds one weighted activation to the running row sum.
  function automatic void weigh_activation(input int w, input int unsigned addr);
    logic signed [31:0] act;
    act = act_mem[addr % ACT_DEPTH];
    if (w > 0) run_sum = run_sum + act;
    else if (w < 0) run_sum = run_sum - act;
  endfunction

  // Applies one accepted transaction and queues the row result that it completes.
  function automatic void advance_row_sum(input matvec_item_t it);
    int unsigned g3;
    int unsigned g2;
    int unsigned total;
    int unsigned base;
    int unsigned rows;
    int          w;
    row_result_t res;
    g3 = reg_three_len / 3;
    g2 = reg_two_len / 2;
    total = g3 + g2;
    if (it.kind == KIND_LOAD) begin
      act_mem[it.act_index] = it.act_value;
      return;
    end
    if (total == 0) return;
    if (grp_pos < g3) begin
      base = grp_pos * 3;
      for (int lane = 0; lane < 3; lane++) begin
        w = triple_weight(it.nibble, lane);
        weigh_activation(it.negate ? -w : w, base + lane);
      end
    end else if (grp_pos < total) begin
      base = reg_three_len + (grp_pos - g3) * 2;
      for (int lane = 0; lane < 2; lane++) begin
        weigh_activation(pair_weight(it.nibble, lane), base + lane);
      end
    end
    if (grp_pos + 1 < total) begin
      grp_pos++;
      return;
    end
    res.row_index = row_pos[7:0];
    res.row_value = it.prior_value + run_sum;
    rows_due.push_back(res);
    rows = reg_row_count;
    if (rows == 0) rows = 1;
    if (rows > ROW_LIMIT) rows = ROW_LIMIT;
    row_pos++;
    if (row_pos >= rows) row_pos = 0;
    grp_pos = 0;
    run_sum = '0;
  endfunction

  function automatic logic signed [15:0] rand_act();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_prior();
    case ($urandom_range(0, 7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic logic [12:0] pick_len();
    case ($urandom_range(0, 15))
      0:       return 13'd0;
      1:       return 13'($urandom);
      2, 3:    return 13'($urandom_range(1, 2));
      default: return 13'($urandom_range(3, 24));
    endcase
  endfunction

  // Row counts cover zero, one, the wrap limit and values above it; upper data bits are noise.
  function automatic logic [12:0] pick_row_count();
    logic [8:0] rc;
    case ($urandom_range(0, 7))
      0:       rc = 9'd0;
      1:       rc = 9'd256;
      2:       rc = 9'($urandom_range(257, 511));
      3:       rc = 9'd511;
      default: rc = 9'($urandom_range(1, 8));
    endcase
    return {4'($urandom), rc};
  endfunction

  task automatic push_load(input logic [11:0] addr, input logic signed [15:0] value);
    matvec_item_t it;
    it.kind        = KIND_LOAD;
    it.act_index   = addr;
    it.act_value   = value;
    it.nibble      = 4'($urandom);
    it.negate      = 1'($urandom);
    it.prior_value = 32'($urandom);
    pending.push_back(it);
  endtask

  task automatic push_group(input logic [3:0] code, input logic neg,
                            input logic signed [31:0] prior);
    matvec_item_t it;
    it.kind        = KIND_GROUP;
    it.act_index   = 12'($urandom);
    it.act_value   = 16'($urandom);
    it.nibble      = code;
    it.negate      = neg;
    it.prior_value = prior;
    pending.push_back(it);
  endtask

  // Weight groups with random content, with the odd activation load mixed in.
  task automatic push_groups(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        push_load(12'($urandom_range(0, ACT_WINDOW - 1)), rand_act());
      end
      push_group(4'($urandom), 1'($urandom), rand_prior());
    end
  endtask

  task automatic write_reg(input logic [tpmv_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tpmv_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      tpmv_pkg::CFG_THREE_LEN: reg_three_len = data;
      tpmv_pkg::CFG_TWO_LEN:   reg_two_len = data;
      tpmv_pkg::CFG_ROW_COUNT: reg_row_count = data[8:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(input logic [12:0] three, input logic [12:0] two,
                              input logic [12:0] rows);
    write_reg(tpmv_pkg::CFG_THREE_LEN, three);
    write_reg(tpmv_pkg::CFG_TWO_LEN, two);
    write_reg(tpmv_pkg::CFG_ROW_COUNT, rows);
    settings_used++;
  endtask

  // Holds until every transaction went in and every row result came out, then lets the pipe drain.
  task automatic wait_idle();
    while (pending.size() != 0 || in_valid || rows_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input driver: bursts of transactions with random gaps in between.
  always @(negedge clk) begin : drive_items
    matvec_item_t nxt;
    if (rst_n && (!in_valid || item_taken)) begin
      if (gap_left == 0 && pending.size() != 0) begin
        nxt = pending.pop_front();
        kind        <= nxt.kind;
        act_index   <= nxt.act_index;
        act_value   <= nxt.act_value;
        nibble      <= nxt.nibble;
        negate      <= nxt.negate;
        prior_value <= nxt.prior_value;
        in_valid    <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
        end
      end else begin
        in_valid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end
    end
  end

  // Output stall: the mode changes at random intervals.
  always @(negedge clk) begin : stall_pattern
    static stall_mode_e mode = STALL_NONE;
    static int unsigned mode_left = 0;
    static int unsigned tick = 0;
    tick++;
    if (mode_left == 0) begin
      mode = stall_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    case (mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 8);
      default:     out_stall <= ((tick % 7) < 3);
    endcase
  end

  // Monitor: predicts on each accepted input transaction and checks each output transaction.
  always @(posedge clk) begin : watch_ports
    matvec_item_t seen;
    row_result_t  want;
    item_taken = rst_n && in_valid && !in_stall;
    if (item_taken) begin
      seen.kind        = kind;
      seen.act_index   = act_index;
      seen.act_value   = act_value;
      seen.nibble      = nibble;
      seen.negate      = negate;
      seen.prior_value = prior_value;
      advance_row_sum(seen);
      items_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (rows_due.size() == 0) begin
        $error("row result with none expected: row_index %0d row_value %0d",
               row_index, row_value);
        mismatch_count++;
      end else begin
        want = rows_due.pop_front();
        if (row_index !== want.row_index) begin
          $error("row_index: expected %0d, got %0d", want.row_index, row_index);
          mismatch_count++;
        end
        if (row_value !== want.row_value) begin
          $error("row_value: expected %0d, got %0d", want.row_value, row_value);
          mismatch_count++;
        end
      end
    end
  end

  // Run plan: a loaded window of the store, reset defaults, directed corners, cut rows at the
  // largest register values, row wrap, then random phases. Open rows are ended before they
  // grow long, so every read falls inside the loaded window.
  initial begin : run_plan
    int unsigned random_groups;
    int unsigned n;
    logic [12:0] three;
    logic [12:0] two;
    random_groups = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Register values after reset: a row of sixteen two-weight groups.
    for (int a = 0; a < ACT_WINDOW; a++) push_load(12'(a), rand_act());
    push_groups(32);
    wait_idle();

    // Every code of both tables, activation and prior extremes, one row per matrix.
    set_geometry(13'd3, 13'd2, 13'd1);
    push_load(12'd0, 16'sh8000);
    push_load(12'd1, 16'sh7FFF);
    push_load(12'd2, -16'sd1);
    push_load(12'd3, 16'sd1);
    push_load(12'd4, 16'sh5A5A);
    for (int r = 0; r < 16; r++) begin
      push_group(4'(r), r[0], rand_prior());
      push_group(4'(15 - r), !r[0], {r[0], {31{r[1]}}});
    end
    wait_idle();

    // Empty rows ignore weight groups; the spare register index does nothing.
    set_geometry(13'd2, 13'd1, 13'd1);
    write_reg(CFG_SPARE, 13'($urandom));
    push_groups(4);
    wait_idle();

    // Registers changed in the middle of a row, first to empty, then to a shorter row.
    set_geometry(13'd3, 13'd2, 13'd0);
    push_group(4'd13, 1'b0, rand_prior());
    wait_idle();
    set_geometry(13'd0, 13'd1, 13'd0);
    push_groups(3);
    wait_idle();
    set_geometry(13'd3, 13'd2, 13'd0);
    push_group(4'd8, 1'b1, rand_prior());
    wait_idle();
    set_geometry(13'd6, 13'd4, 13'd0);
    push_groups(3);
    wait_idle();
    set_geometry(13'd3, 13'd0, 13'd0);
    push_group(4'd5, 1'b0, rand_prior());
    wait_idle();

    // Largest register values; each long row is ended early by a shorter setting.
    set_geometry(13'h1FFF, 13'h1FFF, 13'h1FFF);
    push_groups(12);
    wait_idle();
    set_geometry(13'd3, 13'd0, 13'd1);
    push_group(4'd4, 1'b0, rand_prior());
    wait_idle();
    set_geometry(13'd4096, 13'd4096, 13'd256);
    push_groups(12);
    wait_idle();
    set_geometry(13'd0, 13'h1FFF, 13'd256);
    push_groups(8);
    wait_idle();
    set_geometry(13'd3, 13'd0, 13'd1);
    push_group(4'd9, 1'b1, rand_prior());
    wait_idle();

    // One-group rows past the row limit so the row index wraps.
    set_geometry(13'd0, 13'd2, 13'h1FFF);
    push_groups(264);
    wait_idle();

    // Random geometries; partial rows carry over into the next setting.
    while (random_groups < 200) begin
      three = pick_len();
      two = pick_len();
      set_geometry(three, two, pick_row_count());
      n = $urandom_range(10, 40);
      push_groups(n);
      if (three / 3 + two / 2 != 0) random_groups += n;
      wait_idle();
      if (grp_pos > GP_CAP) begin
        set_geometry(13'd3, 13'd0, pick_row_count());
        push_group(4'($urandom), 1'($urandom), rand_prior());
        wait_idle();
      end
    end

    $display("Covered %0d register settings: reset values, code tables, empty and cut rows,",
             settings_used);
    $display("largest register values and row wrap; %0d transactions in, %0d results checked.",
             items_taken, results_checked);
    if (rows_due.size() != 0) begin
      $error("%0d row results never arrived", rows_due.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
